// ----- rtl/core/font_glyph_pixel_renderer_unit_assert.svh -----
// Assertion macros for the font glyph pixel renderer.
// Self-contained; included by the top level after its port list.
`ifndef FONT_GLYPH_PIXEL_RENDERER_UNIT_ASSERT_SVH
`define FONT_GLYPH_PIXEL_RENDERER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define FGPR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset.
`define FGPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FGPR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define FGPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/fgpr_pkg.sv -----
// Shared types and constants of the font glyph pixel renderer.
// No dependencies; imported by font_glyph_pixel_renderer_unit.
package fgpr_pkg;

   localparam int SCREEN_COLUMNS = 128;

   localparam logic [7:0] FIRST_CODE = 8'h20;
   localparam logic [7:0] LAST_CODE  = 8'h5A;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

   localparam int ROM_DEPTH  = 295;
   localparam int ROM_ADDR_W = $clog2(ROM_DEPTH);

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_COLOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE       = 1'b1;

   localparam logic [15:0] PIXEL_COLOR_RESET = 16'hFFFF;
   localparam logic [3:0]  SCALE_RESET       = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_ADVANCE
   } fgpr_state_type;

   // 5x7 font, one byte per column, bit 0 is the top row; codes space to 'Z'
   localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00,
      8'h00, 8'h07, 8'h00, 8'h07, 8'h00, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14,
      8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
      8'h36, 8'h49, 8'h55, 8'h22, 8'h50, 8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
      8'h00, 8'h1C, 8'h22, 8'h41, 8'h00, 8'h00, 8'h41, 8'h22, 8'h1C, 8'h00,
      8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
      8'h00, 8'h50, 8'h30, 8'h00, 8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
      8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
      8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
      8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
      8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
      8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
      8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
      8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
      8'h00, 8'h08, 8'h14, 8'h22, 8'h41, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
      8'h41, 8'h22, 8'h14, 8'h08, 8'h00, 8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
      8'h32, 8'h49, 8'h79, 8'h41, 8'h3E, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,
      8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
      8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
      8'h7F, 8'h09, 8'h09, 8'h01, 8'h01, 8'h3E, 8'h41, 8'h41, 8'h51, 8'h72,
      8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
      8'h20, 8'h40, 8'h41, 8'h3F, 8'h01, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
      8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F,
      8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
      8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
      8'h7F, 8'h09, 8'h19, 8'h29, 8'h46, 8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
      8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,
      8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,
      8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h03, 8'h04, 8'h78, 8'h04, 8'h03,
      8'h61, 8'h51, 8'h49, 8'h45, 8'h43
   };

endpackage

// ----- rtl/core/font_glyph_pixel_renderer_unit.sv -----
// Top level of the font glyph pixel renderer: 5x7 character generator.
// Depends on fgpr_pkg and font_glyph_pixel_renderer_unit_assert.svh.

// Each request carries one character code. Printable codes (space to 'Z')
// are drawn at the text cursor as one response per set font pixel: a filled
// square of side "scale" at (cursor_x + col*scale, cursor_y + row*scale)
// modulo 256, in pixel_color; tlast marks the last square of a character.
// Pixels come column by column, top row first. After a printable character
// the cursor moves right by 6*scale and wraps to column 0, 8*scale lower,
// once it passes SCREEN_COLUMNS - 6*scale. With new_string set the cursor is
// first loaded from the origin fields, even for a code that draws nothing.
// One request is processed at a time. A printable code is accepted, its five
// font columns are fetched through the one read port of the synchronous font
// ROM, then the walk takes one glyph position per cycle up to the last set
// pixel (at most 35 positions, stalled while the response register is full),
// sees the glyph empty and moves the cursor. The last response may still
// wait in the response register while the next request is accepted.
// Configuration writes are always taken (csr_ready is high) and must only
// happen while the block is idle.
module font_glyph_pixel_renderer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // char_code, origin_x, origin_y
   input  logic                              req_tuser,  // new_string
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // block_x, block_y, block_size,
                                                         // block_color, 4 zero bits
   output logic                              rsp_tlast,  // last_of_char
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fgpr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);
   import fgpr_pkg::*;

   // configuration
   logic [15:0] pixel_color_ff;
   logic [3:0]  scale_ff;

   // cursor and sequencing
   fgpr_state_type state_ff, state_in;
   logic [7:0]  cursor_x_ff, cursor_y_ff;
   logic [ROM_ADDR_W-1:0] base_ff;
   logic [2:0]  ld_cnt_ff;
   logic [GLYPH_BITS-1:0] glyph_ff;
   logic [2:0]  row_ff;
   logic [7:0]  col_off_ff, row_off_ff;

   // font ROM read port
   logic [ROM_ADDR_W-1:0] rom_addr;
   logic [7:0]  rom_q_ff;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_x_ff, rsp_y_ff;
   logic [3:0]  rsp_size_ff;
   logic [15:0] rsp_color_ff;
   logic        rsp_last_ff;

   // request fields
   logic [7:0]  req_code, req_origin_x, req_origin_y;
   logic        req_accept, printable;
   logic [7:0]  code_offset;

   // control
   logic        out_free, glyph_empty, walk_step, emit, load_done;
   logic [7:0]  scale_ext;
   logic [6:0]  six_s, eight_s;
   logic [7:0]  next_x;
   logic signed [9:0] wrap_limit;
   logic        wrap;

   assign req_code     = req_tdata[7:0];
   assign req_origin_x = req_tdata[15:8];
   assign req_origin_y = req_tdata[23:16];
   assign req_accept   = req_tvalid && req_tready;
   assign printable    = (req_code >= FIRST_CODE) && (req_code <= LAST_CODE);
   assign code_offset  = req_code - FIRST_CODE;

   assign csr_ready = 1'b1;

   assign scale_ext = {4'b0000, scale_ff};
   assign six_s     = {1'b0, scale_ff, 2'b00} + {2'b00, scale_ff, 1'b0};
   assign eight_s   = {scale_ff, 3'b000};

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign glyph_empty = (glyph_ff == '0);
   assign load_done   = (ld_cnt_ff == 3'(GLYPH_COLS));

   // cursor move after a glyph: compare as signed; the limit stays positive for every scale
   assign next_x     = cursor_x_ff + {1'b0, six_s};
   assign wrap_limit = 10'(SCREEN_COLUMNS) - {3'b000, six_s};
   assign wrap       = $signed({2'b00, next_x}) > wrap_limit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && printable) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (glyph_empty) state_in = ST_ADVANCE;
         end
         ST_ADVANCE: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      walk_step  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_WALK: walk_step  = !glyph_empty && (!glyph_ff[0] || out_free);
         default: begin
            req_tready = 1'b0;
            walk_step  = 1'b0;
         end
      endcase
   end

   assign emit = walk_step && glyph_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_color_ff <= PIXEL_COLOR_RESET;
         scale_ff       <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_COLOR: pixel_color_ff <= csr_data;
            CSR_SCALE:       scale_ff       <= csr_data[3:0];
            default: begin
               pixel_color_ff <= pixel_color_ff;
               scale_ff       <= scale_ff;
            end
         endcase
      end
   end

   // cursor: load from origin on a new string, move after a printable glyph
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else if (req_accept && req_tuser) begin
         cursor_x_ff <= req_origin_x;
         cursor_y_ff <= req_origin_y;
      end else if (state_ff == ST_ADVANCE) begin
         if (wrap) begin
            cursor_x_ff <= '0;
            cursor_y_ff <= cursor_y_ff + {1'b0, eight_s};
         end else begin
            cursor_x_ff <= next_x;
         end
      end
   end

   // font ROM: issue column reads while loading; the data is registered and arrives in the following cycle
   always_comb begin
      if (ld_cnt_ff < 3'(GLYPH_COLS)) begin
         rom_addr = base_ff + ROM_ADDR_W'(ld_cnt_ff);
      end else begin
         rom_addr = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= GLYPH_ROM[rom_addr];
   end

   // glyph fetch and walk: columns shift in from the top, walk shifts out from bit 0
   always_ff @(posedge clock) begin
      if (req_accept) begin
         // base address is offset * 5
         base_ff   <= {code_offset[6:0], 2'b00} + {2'b00, code_offset[6:0]};
         ld_cnt_ff <= '0;
      end else if (state_ff == ST_LOAD) begin
         ld_cnt_ff <= ld_cnt_ff + 3'd1;
         if (ld_cnt_ff != 3'd0) begin
            glyph_ff <= {rom_q_ff[GLYPH_ROWS-1:0], glyph_ff[GLYPH_BITS-1:GLYPH_ROWS]};
         end
         row_ff     <= '0;
         col_off_ff <= '0;
         row_off_ff <= '0;
      end else if (walk_step) begin
         glyph_ff <= glyph_ff >> 1;
         if (row_ff == 3'(GLYPH_ROWS - 1)) begin
            row_ff     <= '0;
            row_off_ff <= '0;
            col_off_ff <= col_off_ff + scale_ext;
         end else begin
            row_ff     <= row_ff + 3'd1;
            row_off_ff <= row_off_ff + scale_ext;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff     <= cursor_x_ff + col_off_ff;
         rsp_y_ff     <= cursor_y_ff + row_off_ff;
         rsp_size_ff  <= scale_ff;
         rsp_color_ff <= pixel_color_ff;
         // last block when no set pixel remains beyond this one
         rsp_last_ff  <= (glyph_ff[GLYPH_BITS-1:1] == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_color_ff, rsp_size_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

`include "font_glyph_pixel_renderer_unit_assert.svh"

   `FGPR_ASSERT_IMPLIES(a_emit_needs_room, clock, reset, emit, out_free, "block emitted into a full response register")
   `FGPR_ASSERT_NEXT(a_last_empties_glyph, clock, reset, emit && (glyph_ff[GLYPH_BITS-1:1] == '0), glyph_ff == '0, "pixels left after last block")
   `FGPR_ASSERT_NEXT(a_cursor_held_in_walk, clock, reset, state_ff == ST_WALK, $stable(cursor_x_ff) && $stable(cursor_y_ff), "cursor moved during glyph walk")

endmodule

// ----- sim/glyph_block_checker.sv -----
// Checker for the font glyph pixel renderer: watches the request, response
// and configuration channels, predicts every drawn block and compares it.
// Depends on fgpr_pkg for the font table, the code range and register indexes.
module glyph_block_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // char_code, origin_x, origin_y
   input  logic                             req_tuser,   // new_string
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [39:0]                      rsp_tdata,   // block_x, block_y, block_size, block_color
   input  logic                             rsp_tlast,   // last_of_char
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [fgpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data,
   output int                               mismatch_count,
   output int                               blocks_pending
);
   import fgpr_pkg::*;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [3:0]  size;
      logic [15:0] color;
      logic        last;
   } glyph_block_type;

   glyph_block_type expected_blocks[$];

   logic [15:0] color_reg;
   logic [3:0]  scale_reg;
   logic [7:0]  pen_x;
   logic [7:0]  pen_y;
   int          errors;

   // Queue the blocks of one character and move the pen past it.
   task automatic render_glyph(input logic [7:0] code, input logic fresh,
                               input logic [7:0] ox, input logic [7:0] oy);
      int              base;
      int              limit;
      logic [7:0]      column_bits;
      glyph_block_type held;
      bit              have_held;
      have_held = 1'b0;
      if (fresh) begin
         pen_x = ox;
         pen_y = oy;
      end
      if (code < FIRST_CODE || code > LAST_CODE)
         return;
      base = (int'(code) - int'(FIRST_CODE)) * GLYPH_COLS;
      for (int col = 0; col < GLYPH_COLS; col++) begin
         column_bits = GLYPH_ROM[base + col];
         for (int row = 0; row < GLYPH_ROWS; row++) begin
            if (column_bits[row]) begin
               if (have_held)
                  expected_blocks.push_back(held);
               held.x     = 8'(int'(pen_x) + col * int'(scale_reg));
               held.y     = 8'(int'(pen_y) + row * int'(scale_reg));
               held.size  = scale_reg;
               held.color = color_reg;
               held.last  = 1'b0;
               have_held  = 1'b1;
            end
         end
      end
      // the final set pixel closes the character
      if (have_held) begin
         held.last = 1'b1;
         expected_blocks.push_back(held);
      end
      pen_x = 8'(int'(pen_x) + 6 * int'(scale_reg));
      limit = SCREEN_COLUMNS - 6 * int'(scale_reg);
      if (int'(pen_x) > limit) begin
         pen_x = 8'd0;
         pen_y = 8'(int'(pen_y) + 8 * int'(scale_reg));
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      glyph_block_type want;
      if (reset) begin
         expected_blocks.delete();
         color_reg = PIXEL_COLOR_RESET;
         scale_reg = SCALE_RESET;
         pen_x     = 8'd0;
         pen_y     = 8'd0;
         errors    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               $error("block at x %0d y %0d with none expected",
                      rsp_tdata[7:0], rsp_tdata[15:8]);
               errors++;
            end else begin
               want = expected_blocks.pop_front();
               check_field("block_x", want.x, rsp_tdata[7:0]);
               check_field("block_y", want.y, rsp_tdata[15:8]);
               check_field("block_size", want.size, rsp_tdata[19:16]);
               check_field("block_color", want.color, rsp_tdata[35:20]);
               check_field("last_of_char", want.last, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PIXEL_COLOR: color_reg = csr_data;
               CSR_SCALE:       scale_reg = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            render_glyph(req_tdata[7:0], req_tuser, req_tdata[15:8], req_tdata[23:16]);
      end
      mismatch_count <= errors;
      blocks_pending <= expected_blocks.size();
   end

endmodule

// ----- sim/font_glyph_pixel_renderer_unit_tb.sv -----
// Testbench top of the font glyph pixel renderer: drives character requests
// and register writes, stalls both channels at random, and gives the verdict.
// Depends on fgpr_pkg, glyph_block_checker and font_glyph_pixel_renderer_unit.
module font_glyph_pixel_renderer_unit_tb;
   import fgpr_pkg::*;

   // worst case is far below this: ~440 characters of 35 stalled blocks each
   localparam int CYCLE_LIMIT  = 1_000_000;
   // wait long enough for the block to finish a character after its request
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_CHARS  = 64;
   localparam int PHASES       = 6;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_PIXEL_COLOR;
   logic [15:0]            csr_data   = '0;

   int mismatch_count;
   int blocks_pending;
   int cycle_count = 0;
   int stall_left  = 0;
   bit calm        = 1'b0;   // set for the last phase: no idling on either side

   font_glyph_pixel_renderer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   glyph_block_checker block_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .blocks_pending (blocks_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("font_glyph_pixel_renderer_unit_tb: errors");
         $finish;
      end
   end

   // Response sink: drop tready in bursts of random length, hold it high
   // otherwise; the random start gives long stall-free stretches as well.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one request, maybe after an idle burst, and hold it until taken.
   // tvalid stays high between back-to-back requests.
   task automatic send_char(input logic [7:0] code, input logic fresh,
                            input logic [7:0] ox, input logic [7:0] oy);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {oy, ox, code};
      req_tuser  <= fresh;
      do @(posedge clock); while (!req_tready);
   endtask

   // Write one register; lower valid for a cycle so writes never overlap.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every expected block is in, then give the block time to
   // finish a trailing character that draws nothing.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blocks_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_style(input logic [15:0] color, input logic [3:0] scale);
      settle();
      write_reg(CSR_PIXEL_COLOR, color);
      // upper data bits are junk for the scale register
      write_reg(CSR_SCALE, {12'($urandom), scale});
   endtask

   // Mostly strings: a fresh origin, then a run of printable codes. Mix in
   // unprintable noise, some of it reloading the cursor mid-string.
   task automatic text_phase(input logic [15:0] color, input logic [3:0] scale);
      int         printed;
      int         run;
      logic [7:0] noise;
      printed = 0;
      set_style(color, scale);
      while (printed < PHASE_CHARS) begin
         if ($urandom_range(0, 6) == 0) begin
            noise = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                         : 8'($urandom_range(91, 255));
            send_char(noise, 1'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            run = $urandom_range(1, 12);
            send_char(8'($urandom_range(FIRST_CODE, LAST_CODE)), 1'b1,
                      8'($urandom), 8'($urandom));
            for (int k = 1; k < run; k++)
               send_char(8'($urandom_range(FIRST_CODE, LAST_CODE)), 1'b0,
                         8'($urandom), 8'($urandom));
            printed += run;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset style: white, scale 1, cursor at the origin.
      send_char("A", 1'b0, 8'h00, 8'h00);
      send_char("#", 1'b0, 8'h00, 8'h00);
      send_char(" ", 1'b0, 8'h00, 8'h00);       // blank glyph still advances
      send_char(8'h00, 1'b1, 8'hFF, 8'hFF);     // unprintable, but loads the cursor
      send_char("Z", 1'b0, 8'h00, 8'h00);       // draws across the 256 wrap
      send_char(8'h1F, 1'b0, 8'hFF, 8'hFF);
      send_char(8'h5B, 1'b1, 8'h10, 8'h20);
      send_char(8'hFF, 1'b0, 8'h00, 8'h00);
      send_char("!", 1'b0, 8'h00, 8'h00);
      send_char("W", 1'b1, 8'd116, 8'h00);      // the next one passes the right edge
      send_char("X", 1'b0, 8'h00, 8'h00);
      send_char("0", 1'b0, 8'h00, 8'h00);

      // Largest nominal scale, black.
      set_style(16'h0000, 4'd8);
      send_char("M", 1'b1, 8'h00, 8'h00);
      send_char("N", 1'b0, 8'h00, 8'h00);
      send_char("@", 1'b0, 8'h00, 8'h00);

      // Scale 0: zero-size blocks piled on the cursor; past the right edge
      // it still wraps to column 0 without moving down.
      set_style(16'hA5A5, 4'd0);
      send_char("O", 1'b1, 8'd200, 8'd200);
      send_char("O", 1'b0, 8'h00, 8'h00);

      // Scale 15: the wrap limit drops to 38, so both characters wrap.
      set_style(16'hFFFF, 4'd15);
      send_char("Q", 1'b1, 8'd250, 8'd3);
      send_char("R", 1'b0, 8'h00, 8'h00);
      send_char(8'h80, 1'b1, 8'h55, 8'hAA);

      set_style(16'h5A5A, 4'd9);
      send_char("B", 1'b0, 8'h00, 8'h00);
      send_char("8", 1'b0, 8'h00, 8'h00);

      // Random text under a new style per phase; the last phase runs calm.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1)
            calm = 1'b1;
         case (phase)
            0:       text_phase(16'($urandom), 4'd1);
            1:       text_phase(16'($urandom), 4'd8);
            2:       text_phase(16'($urandom), 4'd0);
            3:       text_phase(16'($urandom), 4'($urandom_range(9, 15)));
            default: text_phase(16'($urandom), 4'($urandom_range(1, 8)));
         endcase
      end

      settle();
      if (mismatch_count == 0)
         $display("font_glyph_pixel_renderer_unit_tb: clean");
      else
         $display("font_glyph_pixel_renderer_unit_tb: errors");
      $finish;
   end

endmodule
